[rtl/atm_pkg.sv]
// ----------------------------------------------------------------------------
// atm_pkg: shared types and constants for the alarm table
// Item and result structs, command codes, table sizing.
// ----------------------------------------------------------------------------
package atm_pkg;

	// table capacity (1..8, set by the 3-bit index field)
	localparam int MAX_ENTRIES = 8;

	// index into the table storage
	localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	// pointers and entry count: must hold MAX_ENTRIES and the 3-bit index field
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int PTR_W = (CNT_W > 3) ? CNT_W : 3;

	localparam logic [4:0] LAST_HOUR        = 5'd23;
	localparam logic [5:0] MINUTES_PER_HOUR = 6'd60;

	typedef enum logic [1:0] {
		FUNC_ADD    = 2'd0,
		FUNC_REMOVE = 2'd1,
		FUNC_READ   = 2'd2,
		FUNC_TICK   = 2'd3
	} func_t;

	typedef struct packed {
		func_t       func;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic [7:0]  song;
		logic [2:0]  index;
	} alarm_in_t;

	typedef struct packed {
		logic        ok;
		logic [4:0]  entry_hour;
		logic [5:0]  entry_minute;
		logic [7:0]  entry_song;
		logic [3:0]  alarm_count;
		logic        fired;
		logic [7:0]  fired_song;
	} alarm_out_t;

	// one stored alarm
	typedef struct packed {
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [7:0]  song;
	} entry_t;

endpackage

[rtl/alarm_table_time_match.sv]
// ----------------------------------------------------------------------------
// alarm_table_time_match: alarm table with add/remove/read and time match
// Flow: an accepted item walks n entries (n = 0..MAX_ENTRIES) in SCAN, then FINISH, then OUT;
//   refused commands go from IDLE straight to OUT.
// Handshake: one item at a time; the next is taken in the cycle after the result
//   is taken. The walk is set by the single read port of the table memory.
// Reset: arst_n clears entry count, running marks, sequencer and output valid.
// ----------------------------------------------------------------------------
module alarm_table_time_match (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  atm_pkg::alarm_in_t   in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output atm_pkg::alarm_out_t  out_data
);

	// Sequencer:
	//   IDLE   - take an item, check range/index, set up a walk [rd_ptr, stop)
	//   SCAN   - read one entry per cycle; the entry read last cycle is
	//            evaluated while the next one is fetched
	//   FINISH - final table write / count update, build the result
	//   OUT    - hold the result until taken
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH,
		ST_OUT
	} state_t;

	state_t                          state_q;
	atm_pkg::alarm_in_t              item_q;
	atm_pkg::alarm_out_t             out_q;
	logic [atm_pkg::PTR_W-1:0]       count_q;
	logic [atm_pkg::PTR_W-1:0]       rd_ptr_q;
	logic [atm_pkg::PTR_W-1:0]       stop_q;
	logic [atm_pkg::PTR_W-1:0]       ev_ptr_q;
	logic                            ev_vld_q;
	logic [atm_pkg::MAX_ENTRIES-1:0] marks_q;
	logic                            dup_q;
	logic                            fired_q;
	logic [7:0]                      fsong_q;
	atm_pkg::entry_t                 ent_q;

	// table storage: one write port, one registered read port
	atm_pkg::entry_t                 mem [atm_pkg::MAX_ENTRIES];
	atm_pkg::entry_t                 mem_rdata_q;
	logic                            mem_we;
	logic [atm_pkg::IDX_W-1:0]       mem_waddr;
	atm_pkg::entry_t                 mem_wdata;
	logic [atm_pkg::IDX_W-1:0]       mem_raddr;

	logic                            accept;
	logic [atm_pkg::PTR_W-1:0]       idx_ext;
	logic [atm_pkg::PTR_W-1:0]       cnt_next;
	logic [atm_pkg::IDX_W-1:0]       ev_ix;
	logic [atm_pkg::IDX_W-1:0]       ev_ix_dn;
	logic                            ev_match;
	atm_pkg::alarm_out_t             fail_res;
	atm_pkg::alarm_out_t             fin_res;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign out_data  = out_q;
	assign accept    = in_valid && in_ready;

	assign idx_ext   = atm_pkg::PTR_W'(in_data.index);
	assign ev_ix     = ev_ptr_q[atm_pkg::IDX_W-1:0];
	// remove walk starts at index+1, so ev_ptr is never zero there
	assign ev_ix_dn  = atm_pkg::IDX_W'(ev_ptr_q - atm_pkg::PTR_W'(1));
	assign ev_match  = (mem_rdata_q.hour == item_q.hour) &&
		(mem_rdata_q.minute == item_q.minute);
	assign mem_raddr = rd_ptr_q[atm_pkg::IDX_W-1:0];

	// count after this item
	always_comb begin
		cnt_next = count_q;
		unique case (item_q.func)
			atm_pkg::FUNC_ADD:    if (!dup_q) cnt_next = count_q + atm_pkg::PTR_W'(1);
			atm_pkg::FUNC_REMOVE: cnt_next = count_q - atm_pkg::PTR_W'(1);
			atm_pkg::FUNC_READ,
			atm_pkg::FUNC_TICK:   cnt_next = count_q;
		endcase
	end

	always_comb begin
		fail_res             = '0;
		fail_res.alarm_count = 4'(count_q);

		fin_res              = '0;
		fin_res.entry_hour   = ent_q.hour;
		fin_res.entry_minute = ent_q.minute;
		fin_res.entry_song   = ent_q.song;
		fin_res.alarm_count  = 4'(cnt_next);
		fin_res.fired        = fired_q;
		fin_res.fired_song   = fsong_q;
		unique case (item_q.func)
			atm_pkg::FUNC_ADD:    fin_res.ok = !dup_q;
			atm_pkg::FUNC_REMOVE,
			atm_pkg::FUNC_READ:   fin_res.ok = 1'b1;
			atm_pkg::FUNC_TICK:   fin_res.ok = 1'b0;
		endcase
	end

	// table write: shift-down during a remove walk, append at the end of an add
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = ev_ix_dn;
		mem_wdata = mem_rdata_q;
		if (state_q == ST_SCAN && ev_vld_q && item_q.func == atm_pkg::FUNC_REMOVE) begin
			mem_we = 1'b1;
		end else if (state_q == ST_FINISH && item_q.func == atm_pkg::FUNC_ADD && !dup_q) begin
			mem_we           = 1'b1;
			mem_waddr        = count_q[atm_pkg::IDX_W-1:0];
			mem_wdata.hour   = item_q.hour;
			mem_wdata.minute = item_q.minute;
			mem_wdata.song   = item_q.song;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		mem_rdata_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			marks_q  <= '0;
			ev_vld_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						item_q   <= in_data;
						dup_q    <= 1'b0;
						fired_q  <= 1'b0;
						fsong_q  <= '0;
						ent_q    <= '0;
						ev_vld_q <= 1'b0;
						state_q  <= ST_SCAN;
						unique case (in_data.func)
							atm_pkg::FUNC_ADD: begin
								// full table or time out of range: refuse at once
								if (count_q >= atm_pkg::PTR_W'(atm_pkg::MAX_ENTRIES) ||
									in_data.hour > atm_pkg::LAST_HOUR ||
									in_data.minute >= atm_pkg::MINUTES_PER_HOUR) begin
									out_q   <= fail_res;
									state_q <= ST_OUT;
								end
								rd_ptr_q <= '0;
								stop_q   <= count_q;
							end
							atm_pkg::FUNC_REMOVE: begin
								if (idx_ext >= count_q) begin
									out_q   <= fail_res;
									state_q <= ST_OUT;
								end
								rd_ptr_q <= idx_ext + atm_pkg::PTR_W'(1);
								stop_q   <= count_q;
							end
							atm_pkg::FUNC_READ: begin
								if (idx_ext >= count_q) begin
									out_q   <= fail_res;
									state_q <= ST_OUT;
								end
								rd_ptr_q <= idx_ext;
								stop_q   <= idx_ext + atm_pkg::PTR_W'(1);
							end
							atm_pkg::FUNC_TICK: begin
								rd_ptr_q <= '0;
								stop_q   <= count_q;
							end
						endcase
					end
				end

				ST_SCAN: begin
					// fetch side
					if (rd_ptr_q < stop_q) begin
						ev_vld_q <= 1'b1;
						ev_ptr_q <= rd_ptr_q;
						rd_ptr_q <= rd_ptr_q + atm_pkg::PTR_W'(1);
					end else begin
						ev_vld_q <= 1'b0;
						state_q  <= ST_FINISH;
					end
					// evaluate side: entry fetched last cycle
					if (ev_vld_q) begin
						unique case (item_q.func)
							atm_pkg::FUNC_ADD: begin
								if (ev_match) dup_q <= 1'b1;
							end
							atm_pkg::FUNC_REMOVE: begin
								// running mark moves down with its entry
								marks_q[ev_ix_dn] <= marks_q[ev_ix];
							end
							atm_pkg::FUNC_READ: begin
								ent_q <= mem_rdata_q;
							end
							atm_pkg::FUNC_TICK: begin
								if (!marks_q[ev_ix]) begin
									if (ev_match && item_q.second == '0) begin
										marks_q[ev_ix] <= 1'b1;
										// lowest index wins the song
										if (!fired_q) begin
											fired_q <= 1'b1;
											fsong_q <= mem_rdata_q.song;
										end
									end
								end else if (item_q.second != '0) begin
									marks_q[ev_ix] <= 1'b0;
								end
							end
						endcase
					end
				end

				ST_FINISH: begin
					out_q   <= fin_res;
					count_q <= cnt_next;
					if (item_q.func == atm_pkg::FUNC_ADD && !dup_q) begin
						marks_q[count_q[atm_pkg::IDX_W-1:0]] <= 1'b0;
					end else if (item_q.func == atm_pkg::FUNC_REMOVE) begin
						// slot vacated at the top of the table
						marks_q[cnt_next[atm_pkg::IDX_W-1:0]] <= 1'b0;
					end
					state_q <= ST_OUT;
				end

				ST_OUT: begin
					if (out_ready) state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// count never passes capacity
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= atm_pkg::PTR_W'(atm_pkg::MAX_ENTRIES))
		else $error("entry count above capacity");

	// running marks above the stored entries stay clear between items
	a_marks_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> ((marks_q >> count_q) == '0))
		else $error("running mark set beyond entry count");

	// taking a result frees the block for the next item
	a_ready_after_out: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready) |=> (in_ready && !out_valid))
		else $error("block not ready after result taken");

	// a fire only comes from a tick, and a fired result never reports success
	a_fire_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.fired) |-> (item_q.func == atm_pkg::FUNC_TICK && !out_data.ok))
		else $error("fired flag on a non-tick result");

endmodule

[test/alarm_table_time_match_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// alarm_table_time_match_tb: self-checking bench for the alarm table
// Commands go in over a valid/ready channel. An in-bench copy of the table
// works out each answer when its command is taken, and the checker compares
// every answer field by field with the oldest one still waiting. The run has
// a short directed part, one long output stall, one pause on the input side,
// and then random traffic built around the stored alarm times so that ticks
// really fire.
// ----------------------------------------------------------------------------
module alarm_table_time_match_tb;

	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 20;
	localparam int RANDOM_ITEMS  = 1540;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	atm_pkg::alarm_in_t   in_data = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	atm_pkg::alarm_out_t  out_data;

	// in-bench copy of the alarm table
	logic [4:0]  alarm_hour_tbl [atm_pkg::MAX_ENTRIES];
	logic [5:0]  alarm_minute_tbl [atm_pkg::MAX_ENTRIES];
	logic [7:0]  alarm_song_tbl [atm_pkg::MAX_ENTRIES];
	logic        ringing [atm_pkg::MAX_ENTRIES];
	int          alarms_stored = 0;

	atm_pkg::alarm_out_t  pending_answers [$];
	int          mismatches = 0;
	int          answers_seen = 0;
	int          cycle_count = 0;

	// idling control: no_gaps is shared by both sides, hold and stall are receiver-only
	bit          no_gaps = 1'b0;
	bit          hold_request = 1'b0;
	int          hold_left = 0;
	int          stall_left = 0;

	alarm_table_time_match dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Table behavior: applies one command to the copy, returns its answer
	// ------------------------------------------------------------------
	function automatic atm_pkg::alarm_out_t apply_command(input atm_pkg::alarm_in_t cmd);
		atm_pkg::alarm_out_t ans;
		logic       accept;
		int         i;
		ans = '0;
		case (cmd.func)
			atm_pkg::FUNC_ADD: begin
				// refused when full, out of range, or same hour:minute exists
				accept = (alarms_stored < atm_pkg::MAX_ENTRIES)
					&& (cmd.hour <= atm_pkg::LAST_HOUR)
					&& (cmd.minute < atm_pkg::MINUTES_PER_HOUR);
				for (i = 0; i < alarms_stored; i++) begin
					if (alarm_hour_tbl[i] == cmd.hour && alarm_minute_tbl[i] == cmd.minute)
						accept = 1'b0;
				end
				if (accept) begin
					alarm_hour_tbl[alarms_stored]   = cmd.hour;
					alarm_minute_tbl[alarms_stored] = cmd.minute;
					alarm_song_tbl[alarms_stored]   = cmd.song;
					ringing[alarms_stored]          = 1'b0;
					alarms_stored++;
					ans.ok = 1'b1;
				end
			end
			atm_pkg::FUNC_REMOVE: begin
				// later entries slide down, running marks with them
				if (int'(cmd.index) < alarms_stored) begin
					for (i = int'(cmd.index) + 1; i < alarms_stored; i++) begin
						alarm_hour_tbl[i-1]   = alarm_hour_tbl[i];
						alarm_minute_tbl[i-1] = alarm_minute_tbl[i];
						alarm_song_tbl[i-1]   = alarm_song_tbl[i];
						ringing[i-1]          = ringing[i];
					end
					alarms_stored--;
					ringing[alarms_stored] = 1'b0;
					ans.ok = 1'b1;
				end
			end
			atm_pkg::FUNC_READ: begin
				if (int'(cmd.index) < alarms_stored) begin
					ans.entry_hour   = alarm_hour_tbl[cmd.index];
					ans.entry_minute = alarm_minute_tbl[cmd.index];
					ans.entry_song   = alarm_song_tbl[cmd.index];
					ans.ok           = 1'b1;
				end
			end
			atm_pkg::FUNC_TICK: begin
				// fire on hh:mm:00 if idle; any nonzero second clears the mark
				for (i = 0; i < alarms_stored; i++) begin
					if (!ringing[i]) begin
						if (alarm_hour_tbl[i] == cmd.hour && alarm_minute_tbl[i] == cmd.minute
								&& cmd.second == 6'd0) begin
							ringing[i] = 1'b1;
							if (!ans.fired) begin
								ans.fired      = 1'b1;
								ans.fired_song = alarm_song_tbl[i];
							end
						end
					end else if (cmd.second != 6'd0) begin
						ringing[i] = 1'b0;
					end
				end
			end
			default: ;
		endcase
		ans.alarm_count = 4'(alarms_stored);
		return ans;
	endfunction

	// ------------------------------------------------------------------
	// Idle lengths: mostly none or short, now and then a long one
	// ------------------------------------------------------------------
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps)
			return 0;
		if (r < 50)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic atm_pkg::alarm_in_t make_item(input atm_pkg::func_t f, input int hr,
			input int mn, input int sc, input int sg, input int idx);
		atm_pkg::alarm_in_t it;
		it.func   = f;
		it.hour   = 5'(hr);
		it.minute = 6'(mn);
		it.second = 6'(sc);
		it.song   = 8'(sg);
		it.index  = 3'(idx);
		return it;
	endfunction

	// ------------------------------------------------------------------
	// Sender: optional gap, then hold valid until the item is taken.
	// Valid is only lowered when a gap follows, so back-to-back items
	// never see valid dropped and raised in one step.
	// ------------------------------------------------------------------
	task automatic send_item(input atm_pkg::alarm_in_t item);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			in_data  <= $bits(atm_pkg::alarm_in_t)'($urandom);
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pending_answers.push_back(apply_command(item));
	endtask

	task automatic wait_all_answers();
		while (pending_answers.size() != 0)
			@(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Receiver: random stalls, plus one long hold on request
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (hold_request) begin
			hold_request = 1'b0;
			hold_left    = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			if ($urandom_range(0, 3) == 0)
				stall_left = pick_gap();
		end
	end

	// ------------------------------------------------------------------
	// Checker: each taken answer against the oldest one waiting
	// ------------------------------------------------------------------
	always @(posedge clk) begin : check_answers
		atm_pkg::alarm_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_answers.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("answer %0d arrived with nothing pending: ok=%0d cnt=%0d fired=%0d",
						answers_seen, out_data.ok, out_data.alarm_count, out_data.fired);
			end else begin
				want = pending_answers.pop_front();
				if (out_data.ok !== want.ok || out_data.entry_hour !== want.entry_hour
						|| out_data.entry_minute !== want.entry_minute
						|| out_data.entry_song !== want.entry_song
						|| out_data.alarm_count !== want.alarm_count
						|| out_data.fired !== want.fired
						|| out_data.fired_song !== want.fired_song) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("answer %0d exp: ok=%0d hr=%0d mn=%0d sg=%0d cnt=%0d fired=%0d fs=%0d",
							answers_seen, want.ok, want.entry_hour, want.entry_minute,
							want.entry_song, want.alarm_count, want.fired, want.fired_song);
						$display("answer %0d got: ok=%0d hr=%0d mn=%0d sg=%0d cnt=%0d fired=%0d fs=%0d",
							answers_seen, out_data.ok, out_data.entry_hour, out_data.entry_minute,
							out_data.entry_song, out_data.alarm_count, out_data.fired,
							out_data.fired_song);
					end
				end
			end
			answers_seen++;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Directed tests
	// ------------------------------------------------------------------

	// reads, removes and ticks against an empty table
	task automatic test_empty_table();
		send_item(make_item(atm_pkg::FUNC_READ, 0, 0, 0, 0, 0));
		send_item(make_item(atm_pkg::FUNC_REMOVE, 0, 0, 0, 0, 0));
		send_item(make_item(atm_pkg::FUNC_TICK, 0, 0, 0, 0, 0));
	endtask

	// range limits and duplicate refusal on add, in/out of range read
	task automatic test_add_checks();
		send_item(make_item(atm_pkg::FUNC_ADD, 23, 59, 0, 255, 0));
		send_item(make_item(atm_pkg::FUNC_ADD, 0, 0, 63, 0, 7));
		send_item(make_item(atm_pkg::FUNC_ADD, 24, 0, 0, 1, 0));	// hour too big
		send_item(make_item(atm_pkg::FUNC_ADD, 31, 63, 0, 2, 0));
		send_item(make_item(atm_pkg::FUNC_ADD, 5, 60, 0, 3, 0));	// minute too big
		send_item(make_item(atm_pkg::FUNC_ADD, 23, 59, 0, 7, 0));	// same time again
		send_item(make_item(atm_pkg::FUNC_READ, 0, 0, 0, 0, 0));
		send_item(make_item(atm_pkg::FUNC_READ, 0, 0, 0, 0, 7));	// past the end
	endtask

	// fire, no refire while running, clear on nonzero second, refire
	task automatic test_time_match();
		send_item(make_item(atm_pkg::FUNC_TICK, 23, 59, 0, 0, 0));
		send_item(make_item(atm_pkg::FUNC_TICK, 23, 59, 0, 0, 0));
		send_item(make_item(atm_pkg::FUNC_TICK, 23, 59, 1, 0, 0));
		send_item(make_item(atm_pkg::FUNC_TICK, 23, 59, 0, 0, 0));
		send_item(make_item(atm_pkg::FUNC_TICK, 0, 0, 0, 0, 0));	// song zero still fires
	endtask

	// fill to capacity, refuse one more, remove first, past end and last
	task automatic test_full_table();
		int k;
		for (k = 1; k <= atm_pkg::MAX_ENTRIES - 2; k++)
			send_item(make_item(atm_pkg::FUNC_ADD, k, k, 0, 16 * k, 0));
		send_item(make_item(atm_pkg::FUNC_ADD, 12, 30, 0, 99, 0));	// table full
		send_item(make_item(atm_pkg::FUNC_REMOVE, 0, 0, 0, 0, 0));
		send_item(make_item(atm_pkg::FUNC_REMOVE, 0, 0, 0, 0, 7));
		send_item(make_item(atm_pkg::FUNC_REMOVE, 0, 0, 0, 0, atm_pkg::MAX_ENTRIES - 2));
		send_item(make_item(atm_pkg::FUNC_READ, 0, 0, 0, 0, 0));
	endtask

	// ------------------------------------------------------------------
	// Random traffic, weighted toward real alarm times
	// ------------------------------------------------------------------
	function automatic int likely_hour();
		int pool [4] = '{0, 1, 12, 23};
		if ($urandom_range(0, 99) < 85)
			return pool[$urandom_range(0, 3)];
		return $urandom_range(0, 31);
	endfunction

	function automatic int likely_minute();
		int pool [4] = '{0, 1, 30, 59};
		if ($urandom_range(0, 99) < 85)
			return pool[$urandom_range(0, 3)];
		return $urandom_range(0, 63);
	endfunction

	function automatic atm_pkg::alarm_in_t random_item();
		atm_pkg::alarm_in_t it;
		int        r;
		int        j;
		it = $bits(atm_pkg::alarm_in_t)'($urandom);	// unused fields stay as noise
		r  = $urandom_range(0, 99);
		if (r < 22) begin
			it.func   = atm_pkg::FUNC_ADD;
			it.hour   = 5'(likely_hour());
			it.minute = 6'(likely_minute());
		end else if (r < 37) begin
			it.func = atm_pkg::FUNC_REMOVE;
			if (alarms_stored > 0 && $urandom_range(0, 9) < 7)
				it.index = 3'($urandom_range(0, alarms_stored - 1));
		end else if (r < 50) begin
			it.func = atm_pkg::FUNC_READ;
			if (alarms_stored > 0 && $urandom_range(0, 9) < 7)
				it.index = 3'($urandom_range(0, alarms_stored - 1));
		end else begin
			it.func = atm_pkg::FUNC_TICK;
			if (alarms_stored > 0 && $urandom_range(0, 9) < 7) begin
				j         = $urandom_range(0, alarms_stored - 1);
				it.hour   = alarm_hour_tbl[j];
				it.minute = alarm_minute_tbl[j];
			end else begin
				it.hour   = 5'(likely_hour());
				it.minute = 6'(likely_minute());
			end
			it.second = ($urandom_range(0, 1) == 0) ? 6'd0 : 6'($urandom_range(1, 63));
		end
		return it;
	endfunction

	// output side blocked for a long stretch while commands keep coming
	task automatic test_receiver_hold();
		int k;
		hold_request = 1'b1;
		for (k = 0; k < 20; k++)
			send_item(random_item());
	endtask

	// input side stops until every answer is back, then resumes
	task automatic test_sender_pause();
		int k;
		for (k = 0; k < 5; k++)
			send_item(random_item());
		in_valid <= 1'b0;
		wait_all_answers();
		for (k = 0; k < 5; k++)
			send_item(random_item());
	endtask

	task automatic test_random_traffic(input int n_items);
		int k;
		int j;
		for (k = 0; k < n_items; k++) begin
			// stretches with no idling on either side
			no_gaps = (k % 400) >= 340;
			// now and then empty the table from the front and start over
			if (k % 300 == 299) begin
				for (j = alarms_stored; j > 0; j--)
					send_item(make_item(atm_pkg::FUNC_REMOVE, $urandom_range(0, 31),
						$urandom_range(0, 63), $urandom_range(0, 63),
						$urandom_range(0, 255), 0));
			end
			send_item(random_item());
		end
		no_gaps = 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_table();
		test_add_checks();
		test_time_match();
		test_full_table();
		test_receiver_hold();
		test_sender_pause();
		test_random_traffic(RANDOM_ITEMS);

		in_valid <= 1'b0;
		wait_all_answers();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

[alarm_table_time_match.f]
rtl/atm_pkg.sv
rtl/alarm_table_time_match.sv
test/alarm_table_time_match_tb.sv
